// ----- design/lsnh_pkg.sv -----
package lsnh_pkg;

    localparam int DW         = 32;
    localparam int FB         = 24;
    localparam int SQ_W       = 2 * DW;
    localparam int FQ_DEPTH   = 4;
    localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W   = $clog2(FQ_DEPTH + 1);
    // valid stages in the back part ahead of the output register
    localparam int LAT        = 2 * DW + 3;

    typedef logic [DW-1:0]   word_t;
    typedef logic [SQ_W-1:0] dword_t;

    localparam word_t MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam word_t MAX_POS  = {1'b0, {(DW-1){1'b1}}};

    typedef struct packed {
        word_t vmag;
        logic  vneg;
        word_t gxm;
        word_t gym;
        word_t ax;
        word_t bx;
        word_t ay;
        word_t by;
        logic  strad_x;
        logic  strad_y;
    } lsnh_item_t;

    typedef struct packed {
        word_t vmag;
        logic  vneg;
        word_t ax;
        word_t ay;
        logic  strad_x;
        logic  strad_y;
    } lsnh_side_a_t;

    typedef struct packed {
        word_t h;
        word_t vmag;
        logic  strad_x;
        logic  strad_y;
    } lsnh_side_b_t;

    function automatic word_t mag(input word_t x);
        word_t r;
        r = x[DW-1] ? (~x + 1'b1) : x;
        return r;
    endfunction

endpackage

// ----- design/level_set_normal_hamiltonian_top.sv -----
// Channel  | Handshake            | Beat contents
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | normal_speed, grad_x, grad_y, grad_x_lo/hi, grad_y_lo/hi
// out      | out_valid/ out_ready | hamiltonian, alpha_x, alpha_y
//
// One point enters per cycle and one result leaves per cycle when out_ready is held.
// The path runs through the front register, the queue, two multiply/add stages,
// a DW-stage square-root pipeline, a product stage, a DW-stage divider and the output.
// Reset clears the valid bits of the front, queue and back pipeline; payload is not reset.
// A stalled output freezes the back pipeline; the queue then fills and in_ready drops.
module level_set_normal_hamiltonian_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [lsnh_pkg::DW-1:0]  normal_speed,
    input  logic signed [lsnh_pkg::DW-1:0]  grad_x,
    input  logic signed [lsnh_pkg::DW-1:0]  grad_y,
    input  logic signed [lsnh_pkg::DW-1:0]  grad_x_lo,
    input  logic signed [lsnh_pkg::DW-1:0]  grad_x_hi,
    input  logic signed [lsnh_pkg::DW-1:0]  grad_y_lo,
    input  logic signed [lsnh_pkg::DW-1:0]  grad_y_hi,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [lsnh_pkg::DW-1:0]  hamiltonian,
    output logic        [lsnh_pkg::DW-2:0]  alpha_x,
    output logic        [lsnh_pkg::DW-2:0]  alpha_y
);
    import lsnh_pkg::*;

    logic       fr_valid, fr_ready;
    lsnh_item_t fr_item;
    logic       q_valid, q_ready;
    lsnh_item_t q_item;
    word_t      ham_w;

    lsnh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .normal_speed (normal_speed),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_x_lo    (grad_x_lo),
        .grad_x_hi    (grad_x_hi),
        .grad_y_lo    (grad_y_lo),
        .grad_y_hi    (grad_y_hi),
        .item_valid   (fr_valid),
        .item_ready   (fr_ready),
        .item         (fr_item)
    );

    lsnh_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    lsnh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (q_valid),
        .pop_ready   (q_ready),
        .pop_item    (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hamiltonian (ham_w),
        .alpha_x     (alpha_x),
        .alpha_y     (alpha_y)
    );

    assign hamiltonian = ham_w;

endmodule

// ----- design/lsnh_front.sv -----
module lsnh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsnh_pkg::word_t    normal_speed,
    input  lsnh_pkg::word_t    grad_x,
    input  lsnh_pkg::word_t    grad_y,
    input  lsnh_pkg::word_t    grad_x_lo,
    input  lsnh_pkg::word_t    grad_x_hi,
    input  lsnh_pkg::word_t    grad_y_lo,
    input  lsnh_pkg::word_t    grad_y_hi,
    output logic               item_valid,
    input  logic               item_ready,
    output lsnh_pkg::lsnh_item_t item
);
    import lsnh_pkg::*;

    logic       vld_reg;
    lsnh_item_t item_reg;
    lsnh_item_t item_next;
    word_t      mxl, mxh, myl, myh;

    assign in_ready   = !vld_reg || item_ready;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        mxl = mag(grad_x_lo);
        mxh = mag(grad_x_hi);
        myl = mag(grad_y_lo);
        myh = mag(grad_y_hi);
        item_next.vmag = mag(normal_speed);
        item_next.vneg = normal_speed[DW-1];
        item_next.gxm  = mag(grad_x);
        item_next.gym  = mag(grad_y);
        item_next.ax   = (mxl > mxh) ? mxl : mxh;
        item_next.bx   = (myl < myh) ? myl : myh;
        item_next.ay   = (myl > myh) ? myl : myh;
        item_next.by   = (mxl < mxh) ? mxl : mxh;
        // a bound on one axis collapses to |v| when the other axis straddles zero
        item_next.strad_x = (grad_y_lo == '0) || (grad_y_hi == '0)
                            || (grad_y_lo[DW-1] != grad_y_hi[DW-1]);
        item_next.strad_y = (grad_x_lo == '0) || (grad_x_hi == '0)
                            || (grad_x_lo[DW-1] != grad_x_hi[DW-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- design/lsnh_fifo.sv -----
module lsnh_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  lsnh_pkg::lsnh_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output lsnh_pkg::lsnh_item_t pop_item
);
    import lsnh_pkg::*;

    lsnh_item_t            mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FQ_CNT_W-1:0]   cnt_reg;
    logic                  push, pop;

    assign push_ready = (cnt_reg != FQ_CNT_W'(FQ_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/lsnh_isqrt.sv -----
module lsnh_isqrt (
    input  logic             clk,
    input  logic             en,
    input  lsnh_pkg::dword_t rad,
    output lsnh_pkg::word_t  root
);
    import lsnh_pkg::*;

    // one result bit per stage, digit by digit
    logic [DW:0] rem_reg  [DW];
    word_t       root_reg [DW];
    dword_t      rad_reg  [DW];
    logic [DW:0] rem_next  [DW];
    word_t       root_next [DW];
    dword_t      rad_next  [DW];

    always_comb
    begin
        logic [DW:0]   rem_in;
        word_t         root_in;
        dword_t        rad_in;
        logic [DW+2:0] r2, trial, diff;
        for (int k = 0; k < DW; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = rad;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            r2    = {rem_in, rad_in[SQ_W-1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
            diff  = r2 - trial;
            if (r2 >= trial)
            begin
                rem_next[k]  = diff[DW:0];
                root_next[k] = {root_in[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = r2[DW:0];
                root_next[k] = {root_in[DW-2:0], 1'b0};
            end
            rad_next[k] = rad_in << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root = root_reg[DW-1];

endmodule

// ----- design/lsnh_div.sv -----
module lsnh_div (
    input  logic             clk,
    input  logic             en,
    input  lsnh_pkg::dword_t num,
    input  lsnh_pkg::word_t  den,
    output lsnh_pkg::word_t  quot
);
    import lsnh_pkg::*;

    // restoring division, one quotient bit per stage; the upper half of num
    // is always below den, so the quotient fits in one word
    word_t rem_reg [DW];
    word_t lo_reg  [DW];
    word_t den_reg [DW];
    word_t q_reg   [DW];
    word_t rem_next [DW];
    word_t lo_next  [DW];
    word_t den_next [DW];
    word_t q_next   [DW];

    always_comb
    begin
        word_t       rem_in, lo_in, den_in, q_in;
        logic [DW:0] r2, dd, diff;
        for (int k = 0; k < DW; k++)
        begin
            if (k == 0)
            begin
                rem_in = num[SQ_W-1:DW];
                lo_in  = num[DW-1:0];
                den_in = den;
                q_in   = '0;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                lo_in  = lo_reg[k-1];
                den_in = den_reg[k-1];
                q_in   = q_reg[k-1];
            end
            r2   = {rem_in, lo_in[DW-1]};
            dd   = {1'b0, den_in};
            diff = r2 - dd;
            if (r2 >= dd)
            begin
                rem_next[k] = diff[DW-1:0];
                q_next[k]   = {q_in[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r2[DW-1:0];
                q_next[k]   = {q_in[DW-2:0], 1'b0};
            end
            lo_next[k]  = lo_in << 1;
            den_next[k] = den_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                den_reg[k] <= den_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quot = q_reg[DW-1];

endmodule

// ----- design/lsnh_back.sv -----
module lsnh_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  lsnh_pkg::lsnh_item_t pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [lsnh_pkg::DW-1:0] hamiltonian,
    output logic [lsnh_pkg::DW-2:0] alpha_x,
    output logic [lsnh_pkg::DW-2:0] alpha_y
);
    import lsnh_pkg::*;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic           out_valid_reg;

    dword_t sq_gx_reg, sq_gy_reg, sq_ax_reg, sq_bx_reg, sq_ay_reg, sq_by_reg;
    lsnh_side_a_t side1_reg, side2_reg;
    dword_t sum_m_reg, sum_x_reg, sum_y_reg;
    lsnh_side_a_t side_d_reg [DW];
    word_t  m_root, sx_root, sy_root;

    dword_t prod_h_reg, num_x_reg, num_y_reg;
    word_t  den_x_reg, den_y_reg;
    lsnh_side_a_t side3_reg;
    lsnh_side_b_t sideb_next;
    lsnh_side_b_t sideb_d_reg [DW];
    word_t  qx, qy;

    dword_t shifted;
    word_t  limit, hmag;
    word_t  rx, ry, rx_sat, ry_sat;

    word_t  ham_reg;
    logic [DW-2:0] ax_reg, ay_reg;

    // the whole back pipeline advances unless the output beat is held
    assign en        = !out_valid_reg || out_ready;
    assign pop_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], pop_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    lsnh_isqrt u_sqrt_m (.clk(clk), .en(en), .rad(sum_m_reg), .root(m_root));
    lsnh_isqrt u_sqrt_x (.clk(clk), .en(en), .rad(sum_x_reg), .root(sx_root));
    lsnh_isqrt u_sqrt_y (.clk(clk), .en(en), .rad(sum_y_reg), .root(sy_root));

    lsnh_div u_div_x (.clk(clk), .en(en), .num(num_x_reg), .den(den_x_reg), .quot(qx));
    lsnh_div u_div_y (.clk(clk), .en(en), .num(num_y_reg), .den(den_y_reg), .quot(qy));

    always_comb
    begin
        shifted = prod_h_reg >> FB;
        limit   = side3_reg.vneg ? MOST_NEG : MAX_POS;
        hmag    = (shifted > dword_t'(limit)) ? limit : shifted[DW-1:0];
        sideb_next.h       = side3_reg.vneg ? (~hmag + 1'b1) : hmag;
        sideb_next.vmag    = side3_reg.vmag;
        sideb_next.strad_x = side3_reg.strad_x;
        sideb_next.strad_y = side3_reg.strad_y;

        rx     = sideb_d_reg[DW-1].strad_x ? sideb_d_reg[DW-1].vmag : qx;
        ry     = sideb_d_reg[DW-1].strad_y ? sideb_d_reg[DW-1].vmag : qy;
        rx_sat = (rx > MAX_POS) ? MAX_POS : rx;
        ry_sat = (ry > MAX_POS) ? MAX_POS : ry;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_gx_reg <= dword_t'(pop_item.gxm) * dword_t'(pop_item.gxm);
            sq_gy_reg <= dword_t'(pop_item.gym) * dword_t'(pop_item.gym);
            sq_ax_reg <= dword_t'(pop_item.ax) * dword_t'(pop_item.ax);
            sq_bx_reg <= dword_t'(pop_item.bx) * dword_t'(pop_item.bx);
            sq_ay_reg <= dword_t'(pop_item.ay) * dword_t'(pop_item.ay);
            sq_by_reg <= dword_t'(pop_item.by) * dword_t'(pop_item.by);
            side1_reg.vmag    <= pop_item.vmag;
            side1_reg.vneg    <= pop_item.vneg;
            side1_reg.ax      <= pop_item.ax;
            side1_reg.ay      <= pop_item.ay;
            side1_reg.strad_x <= pop_item.strad_x;
            side1_reg.strad_y <= pop_item.strad_y;

            sum_m_reg <= sq_gx_reg + sq_gy_reg;
            sum_x_reg <= sq_ax_reg + sq_bx_reg;
            sum_y_reg <= sq_ay_reg + sq_by_reg;
            side2_reg <= side1_reg;

            side_d_reg[0] <= side2_reg;
            for (int k = 1; k < DW; k++)
            begin
                side_d_reg[k] <= side_d_reg[k-1];
            end

            prod_h_reg <= dword_t'(side_d_reg[DW-1].vmag) * dword_t'(m_root);
            num_x_reg  <= dword_t'(side_d_reg[DW-1].vmag) * dword_t'(side_d_reg[DW-1].ax);
            num_y_reg  <= dword_t'(side_d_reg[DW-1].vmag) * dword_t'(side_d_reg[DW-1].ay);
            den_x_reg  <= sx_root;
            den_y_reg  <= sy_root;
            side3_reg  <= side_d_reg[DW-1];

            sideb_d_reg[0] <= sideb_next;
            for (int k = 1; k < DW; k++)
            begin
                sideb_d_reg[k] <= sideb_d_reg[k-1];
            end

            ham_reg <= sideb_d_reg[DW-1].h;
            ax_reg  <= rx_sat[DW-2:0];
            ay_reg  <= ry_sat[DW-2:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign hamiltonian = ham_reg;
    assign alpha_x     = ax_reg;
    assign alpha_y     = ay_reg;

endmodule

// ----- design/lsnh_checker.sv -----
module lsnh_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [lsnh_pkg::DW-1:0] hamiltonian,
    input logic [lsnh_pkg::DW-2:0] alpha_x,
    input logic [lsnh_pkg::DW-2:0] alpha_y
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hamiltonian) && $stable(alpha_x)
                                    && $stable(alpha_y))
        else $error("output beat changed while stalled");

    a_rst_out: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    a_rst_in: assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> in_ready)
        else $error("input not ready right after reset");

endmodule

bind level_set_normal_hamiltonian_top lsnh_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hamiltonian (hamiltonian),
    .alpha_x     (alpha_x),
    .alpha_y     (alpha_y)
);
